FILE: src/pta_pkg.sv
package pta_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 64;

    // field widths
    localparam int ID_W       = 12;
    localparam int STR_W      = 8;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT    = 1'b1;

    localparam logic signed [STR_W-1:0] SIGNAL_FLOOR_RESET = -8'sd80;
    localparam logic [TIME_W-1:0]       AGE_LIMIT_RESET    = 32'd9830400;

    // operation codes
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_REFRESHED = 3'd0,
        STATUS_INSERTED  = 3'd1,
        STATUS_WEAK      = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_SWEEP     = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } pta_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } pta_sts_t;

endpackage

FILE: src/pta_ctrl.sv
module pta_ctrl
    import pta_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output pta_cmd_t cmd,
    input  pta_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: src/pta_datapath.sv
module pta_datapath
    import pta_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_operation,
    input  logic [ID_W-1:0]          s_node_id,
    input  logic signed [STR_W-1:0]  s_strength,
    input  logic [TIME_W-1:0]        s_now_time,
    input  pta_cmd_t                 cmd,
    output pta_sts_t                 sts,
    output logic [STATUS_W-1:0]      m_status,
    output logic [SLOT_W-1:0]        m_slot,
    output logic [CNT_W-1:0]         m_expired_count,
    output logic [CNT_W-1:0]         m_active_count
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

    // configuration
    logic signed [STR_W-1:0] floor_reg;
    logic [TIME_W-1:0]       limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= SIGNAL_FLOOR_RESET;
            limit_reg <= AGE_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SIGNAL_FLOOR: floor_reg <= cfg_wdata[STR_W-1:0];
                CFG_AGE_LIMIT:    limit_reg <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // current item
    logic              op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;
    logic              weak_reg;
    logic              skip_reg;
    logic              weak_in;

    // table state
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [TABLE_ENTRIES-1:0] active_reg, active_next;
    logic [CNT_W-1:0]         act_cnt_reg, act_cnt_next;

    // walk state
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0] expired_reg, expired_next;

    // entry memory
    logic [ID_W-1:0]   ids_mem  [TABLE_ENTRIES];
    logic [TIME_W-1:0] seen_mem [TABLE_ENTRIES];
    logic [ID_W-1:0]   rd_id_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;

    // result word
    status_t          out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0] out_expired_reg, out_expired_next;
    logic [CNT_W-1:0] out_active_reg, out_active_next;

    logic [TIME_W-1:0] gap;
    logic              issue_ok;
    logic              scan_last;
    logic              hit_now;
    logic              scan_done;

    assign weak_in = (s_operation == OP_REPORT) && (s_strength <= floor_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            id_reg   <= s_node_id;
            now_reg  <= s_now_time;
            weak_reg <= weak_in;
            skip_reg <= weak_in || (used_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ids_mem[wr_addr]  <= id_reg;
            seen_mem[wr_addr] <= now_reg;
        end
        rd_id_reg   <= ids_mem[scan_idx_reg];
        rd_time_reg <= seen_mem[scan_idx_reg];
    end

    assign gap = (now_reg >= rd_time_reg) ? (now_reg - rd_time_reg)
                                          : (rd_time_reg - now_reg);

    assign issue_ok  = CNT_W'(scan_idx_reg) < used_reg;
    assign scan_last = cmp_valid_reg && (CNT_W'(cmp_idx_reg) == (used_reg - CNT_W'(1)));
    assign hit_now   = cmp_valid_reg && (op_reg == OP_REPORT) && (rd_id_reg == id_reg);
    assign scan_done = skip_reg || hit_now || scan_last;
    assign sts.scan_done = scan_done;

    always_comb begin
        used_next        = used_reg;
        active_next      = active_reg;
        act_cnt_next     = act_cnt_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        expired_next     = expired_reg;
        wr_en            = 1'b0;
        wr_addr          = hit_idx_reg;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_expired_next = out_expired_reg;
        out_active_next  = out_active_reg;

        if (cmd.load) begin
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
            hit_next       = 1'b0;
            expired_next   = '0;
        end

        if (cmd.scan) begin
            // read one entry per cycle, compare it the cycle after
            cmp_valid_next = issue_ok && !scan_done;
            cmp_idx_next   = scan_idx_reg;
            scan_idx_next  = scan_idx_reg + 1'b1;
            if (cmp_valid_reg && !skip_reg) begin
                if (op_reg == OP_REPORT) begin
                    if (hit_now) begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                end else if (active_reg[cmp_idx_reg] && (gap > limit_reg)) begin
                    active_next[cmp_idx_reg] = 1'b0;
                    expired_next = expired_reg + 1'b1;
                    act_cnt_next = act_cnt_reg - 1'b1;
                end
            end
        end

        if (cmd.commit) begin
            out_slot_next    = '0;
            out_expired_next = '0;
            if (op_reg == OP_SWEEP) begin
                out_status_next  = STATUS_SWEEP;
                out_expired_next = expired_reg;
            end else if (weak_reg) begin
                out_status_next = STATUS_WEAK;
            end else if (hit_reg) begin
                wr_en   = 1'b1;
                wr_addr = hit_idx_reg;
                if (!active_reg[hit_idx_reg]) begin
                    act_cnt_next = act_cnt_reg + 1'b1;
                end
                active_next[hit_idx_reg] = 1'b1;
                out_status_next = STATUS_REFRESHED;
                out_slot_next   = SLOT_W'(hit_idx_reg);
            end else if (used_reg < ENTRIES_CNT) begin
                wr_en   = 1'b1;
                wr_addr = used_reg[IDX_W-1:0];
                active_next[used_reg[IDX_W-1:0]] = 1'b1;
                used_next       = used_reg + 1'b1;
                act_cnt_next    = act_cnt_reg + 1'b1;
                out_status_next = STATUS_INSERTED;
                out_slot_next   = SLOT_W'(used_reg);
            end else begin
                out_status_next = STATUS_FULL;
            end
            out_active_next = act_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            active_reg    <= '0;
            act_cnt_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            used_reg      <= used_next;
            active_reg    <= active_next;
            act_cnt_reg   <= act_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_idx_reg     <= hit_idx_next;
        expired_reg     <= expired_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_expired_reg <= out_expired_next;
        out_active_reg  <= out_active_next;
    end

    assign m_status        = out_status_reg;
    assign m_slot          = out_slot_reg;
    assign m_expired_count = out_expired_reg;
    assign m_active_count  = out_active_reg;

endmodule

FILE: src/presence_table_with_aging.sv
// presence table with aging: tracks up to TABLE_ENTRIES sensor nodes by 12-bit id. a report
// word (operation 0) at or below signal_floor returns "too weak" and changes nothing; a report
// whose id is already in the table refreshes that entry's last-seen time and marks it active;
// an unknown id is appended to the next free slot, or returns "table full" when none is left.
// a sweep word (operation 1) marks inactive every active entry whose absolute time gap to
// now_time exceeds age_limit and returns how many it expired. every input word gives exactly
// one result word carrying the active count after the word. the block works on one word at a
// time: a word walks the entries in use, at most TABLE_ENTRIES, and a refresh stops at the
// matching entry; a weak report or an empty table walks none. the entry memory has a single
// read port, read one entry per cycle. a new word is accepted while the previous result is
// still waiting on m_ready. no clearing pass is needed after reset: active flags are flops and
// entries beyond the fill count are never compared. write configuration only while idle.
module presence_table_with_aging
    import pta_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic [ID_W-1:0]         s_node_id,
    input  logic signed [STR_W-1:0] s_strength,
    input  logic [TIME_W-1:0]       s_now_time,
    // result words
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [SLOT_W-1:0]       m_slot,
    output logic [CNT_W-1:0]        m_expired_count,
    output logic [CNT_W-1:0]        m_active_count
);

    // load / scan / commit commands and the end-of-walk flag
    pta_cmd_t cmd;
    pta_sts_t sts;

    // sequencer: idle, walk the table, post the result word
    pta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // entry memory, active flags, counters, compare and age logic, output register
    pta_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_operation     (s_operation),
        .s_node_id       (s_node_id),
        .s_strength      (s_strength),
        .s_now_time      (s_now_time),
        .cmd             (cmd),
        .sts             (sts),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_expired_count (m_expired_count),
        .m_active_count  (m_active_count)
    );

endmodule

FILE: src/pta_checker.sv
module pta_checker
    import pta_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [SLOT_W-1:0]   m_slot,
    input logic [CNT_W-1:0]    m_expired_count,
    input logic [CNT_W-1:0]    m_active_count
);

    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_active_count))
        else $error("result word changed while stalled");

    // only sweeps expire entries, and sweeps name no slot
    a_expire_sweep_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_SWEEP) |-> (m_expired_count == '0))
        else $error("expired count on a report");

    a_sweep_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_SWEEP) |-> (m_slot == '0))
        else $error("slot set on a sweep");

    // refreshed or inserted entries are active, and the count never exceeds the table
    a_active_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_active_count <= ENTRIES_CNT) &&
            (((m_status != STATUS_INSERTED) && (m_status != STATUS_REFRESHED)) ||
             (m_active_count != '0)))
        else $error("active count out of range");

endmodule

bind presence_table_with_aging pta_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_pta_checker (.*);
